[design/rlb_pkg.sv]
// ----------------------------------------------------------------------------
// rlb_pkg
// Types and constants shared by the RGBA layer blend pipeline.
// ----------------------------------------------------------------------------
package rlb_pkg;

	typedef enum logic [3:0] {
		MODE_NORMAL  = 4'd0,
		MODE_ADD     = 4'd1,
		MODE_SUB     = 4'd2,
		MODE_DIFF    = 4'd3,
		MODE_DARKEN  = 4'd4,
		MODE_LIGHTEN = 4'd5,
		MODE_MULT    = 4'd6,
		MODE_DIV     = 4'd7,
		MODE_SCREEN  = 4'd8,
		MODE_OVERLAY = 4'd9
	} blend_mode_t;

	localparam int NumLanes   = 3;
	localparam int BitsPerDiv = 2;
	localparam int DivStages  = 8 / BitsPerDiv;

	typedef struct packed {
		logic [7:0] src_red;
		logic [7:0] src_green;
		logic [7:0] src_blue;
		logic [7:0] src_opacity;
		logic [7:0] dst_red;
		logic [7:0] dst_green;
		logic [7:0] dst_blue;
		logic [7:0] dst_alpha;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} pixel_out_t;

	// One colour channel on its way through the divider
	typedef struct packed {
		logic [8:0] rem;
		logic [7:0] lo;
		logic [7:0] quo;
		logic [8:0] den;
		logic       use_div;
		logic       sat;
		logic [7:0] alt;
	} div_lane_t;

	typedef struct packed {
		div_lane_t [NumLanes-1:0] lanes;
		logic [7:0]               alpha;
	} div_word_t;

endpackage

[design/rlb_arith.sv]
// ----------------------------------------------------------------------------
// rlb_arith
// Five-stage front end: products, alpha, separable modes, divider operands.
// ----------------------------------------------------------------------------
module rlb_arith (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  rlb_pkg::pixel_in_t   pixel,
	input  logic [3:0]           mode,
	output logic                 out_valid,
	output rlb_pkg::div_word_t   word
);
	import rlb_pkg::*;

	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	pixel_in_t           px_s1, px_s2, px_s3, px_s4;
	logic [3:0]          mode_s1, mode_s2, mode_s3, mode_s4;
	logic [7:0]          s_l [NumLanes];
	logic [7:0]          d_l [NumLanes];

	logic [15:0]         ds_s2 [NumLanes];
	logic [15:0]         inv_s2 [NumLanes];
	logic [15:0]         ssa_s2 [NumLanes];
	logic [15:0]         t_s2;

	logic [7:0]          na_s3, dw_s3;
	logic [7:0]          mul_s3 [NumLanes];
	logic [7:0]          scr_s3 [NumLanes];
	logic [15:0]         ssa_s3 [NumLanes];

	logic [7:0]          na_s4;
	logic [7:0]          mul_s4 [NumLanes];
	logic [7:0]          scr_s4 [NumLanes];
	logic [15:0]         ssa_s4 [NumLanes];
	logic [15:0]         ddw_s4 [NumLanes];
	logic [15:0]         dscr_s4 [NumLanes];
	logic [15:0]         imul_s4 [NumLanes];

	div_word_t           word_s5;

	logic [16:0]         t_rnd;
	logic [8:0]          na_wide;
	logic [7:0]          na_c;

	// Lane views of the pixel in stage 1, for the first products
	always_comb begin
		s_l[0] = px_s1.src_red;
		s_l[1] = px_s1.src_green;
		s_l[2] = px_s1.src_blue;
		d_l[0] = px_s1.dst_red;
		d_l[1] = px_s1.dst_green;
		d_l[2] = px_s1.dst_blue;
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: capture
	always_ff @(posedge clk) begin
		px_s1   <= pixel;
		mode_s1 <= mode;
	end

	// Stage 2: first products
	always_ff @(posedge clk) begin
		px_s2   <= px_s1;
		mode_s2 <= mode_s1;
		t_s2    <= (8'd255 - px_s1.dst_alpha) * px_s1.src_opacity;
		for (int i = 0; i < NumLanes; i++) begin
			ds_s2[i]  <= d_l[i] * s_l[i];
			inv_s2[i] <= (8'd255 - d_l[i]) * (8'd255 - s_l[i]);
			ssa_s2[i] <= s_l[i] * px_s1.src_opacity;
		end
	end

	// Stage 3: new alpha, screen and multiply values
	always_comb begin
		t_rnd   = {1'b0, t_s2} + 17'd128;
		na_wide = {1'b0, px_s2.dst_alpha} + 9'((t_rnd + (t_rnd >> 8)) >> 8);
		na_c    = na_wide[8] ? 8'd255 : na_wide[7:0];
	end

	always_ff @(posedge clk) begin
		px_s3   <= px_s2;
		mode_s3 <= mode_s2;
		na_s3   <= na_c;
		dw_s3   <= (na_c >= px_s2.src_opacity) ? na_c - px_s2.src_opacity : 8'd0;
		for (int i = 0; i < NumLanes; i++) begin
			mul_s3[i] <= ds_s2[i][15:8];
			scr_s3[i] <= 8'd255 - inv_s2[i][15:8];
			ssa_s3[i] <= ssa_s2[i];
		end
	end

	// Stage 4: second products
	logic [7:0] d3 [NumLanes];
	always_comb begin
		d3[0] = px_s3.dst_red;
		d3[1] = px_s3.dst_green;
		d3[2] = px_s3.dst_blue;
	end

	always_ff @(posedge clk) begin
		px_s4   <= px_s3;
		mode_s4 <= mode_s3;
		na_s4   <= na_s3;
		for (int i = 0; i < NumLanes; i++) begin
			mul_s4[i]  <= mul_s3[i];
			scr_s4[i]  <= scr_s3[i];
			ssa_s4[i]  <= ssa_s3[i];
			ddw_s4[i]  <= d3[i] * dw_s3;
			dscr_s4[i] <= d3[i] * scr_s3[i];
			imul_s4[i] <= (8'd255 - d3[i]) * mul_s3[i];
		end
	end

	// Stage 5: select per mode and set up the divider
	logic [7:0]  s4 [NumLanes];
	logic [7:0]  d4 [NumLanes];
	logic [8:0]  sum9 [NumLanes];
	logic [16:0] ovs [NumLanes];
	logic [16:0] num [NumLanes];
	div_word_t   w_c;

	always_comb begin
		s4[0] = px_s4.src_red;
		s4[1] = px_s4.src_green;
		s4[2] = px_s4.src_blue;
		d4[0] = px_s4.dst_red;
		d4[1] = px_s4.dst_green;
		d4[2] = px_s4.dst_blue;
		w_c.alpha = px_s4.src_opacity;
		for (int i = 0; i < NumLanes; i++) begin
			sum9[i] = {1'b0, d4[i]} + {1'b0, s4[i]};
			ovs[i]  = {1'b0, dscr_s4[i]} + {1'b0, imul_s4[i]};
			num[i]  = {1'b0, ssa_s4[i]} + {1'b0, ddw_s4[i]};
			w_c.lanes[i].rem     = {1'b0, num[i][15:8]};
			w_c.lanes[i].lo      = num[i][7:0];
			w_c.lanes[i].quo     = 8'd0;
			w_c.lanes[i].den     = {1'b0, na_s4};
			w_c.lanes[i].use_div = 1'b0;
			w_c.lanes[i].sat     = 1'b0;
			w_c.lanes[i].alt     = d4[i];
			case (mode_s4)
				MODE_NORMAL: begin
					w_c.lanes[i].use_div = (px_s4.src_opacity != 8'd0) && (na_s4 != 8'd0);
				end
				MODE_ADD:     w_c.lanes[i].alt = sum9[i][8] ? 8'd255 : sum9[i][7:0];
				MODE_SUB:     w_c.lanes[i].alt = (d4[i] > s4[i]) ? d4[i] - s4[i] : 8'd0;
				MODE_DIFF:    w_c.lanes[i].alt = (d4[i] > s4[i]) ? d4[i] - s4[i]
				                                                 : s4[i] - d4[i];
				MODE_DARKEN:  w_c.lanes[i].alt = (d4[i] < s4[i]) ? d4[i] : s4[i];
				MODE_LIGHTEN: w_c.lanes[i].alt = (d4[i] > s4[i]) ? d4[i] : s4[i];
				MODE_MULT:    w_c.lanes[i].alt = mul_s4[i];
				MODE_DIV: begin
					w_c.lanes[i].use_div = 1'b1;
					w_c.lanes[i].sat     = d4[i] > s4[i];
					w_c.lanes[i].rem     = {1'b0, d4[i]};
					w_c.lanes[i].lo      = 8'd0;
					w_c.lanes[i].den     = {1'b0, s4[i]} + 9'd1;
				end
				MODE_SCREEN:  w_c.lanes[i].alt = scr_s4[i];
				MODE_OVERLAY: w_c.lanes[i].alt = ovs[i][15:8];
				default:      w_c.lanes[i].alt = d4[i];
			endcase
		end
		case (mode_s4)
			MODE_NORMAL: begin
				w_c.alpha = w_c.lanes[0].use_div ? na_s4 : px_s4.dst_alpha;
			end
			MODE_ADD, MODE_SUB, MODE_DIFF, MODE_DARKEN, MODE_LIGHTEN,
			MODE_MULT, MODE_DIV, MODE_SCREEN, MODE_OVERLAY: begin
				w_c.alpha = px_s4.src_opacity;
			end
			default: w_c.alpha = px_s4.dst_alpha;
		endcase
	end

	always_ff @(posedge clk) begin
		word_s5 <= w_c;
	end

	assign out_valid = v_s5;
	assign word      = word_s5;

endmodule

[design/rlb_div_stage.sv]
// ----------------------------------------------------------------------------
// rlb_div_stage
// One registered step of the restoring divider: two quotient bits per lane.
// ----------------------------------------------------------------------------
module rlb_div_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rlb_pkg::div_word_t  word_in,
	output logic                out_valid,
	output rlb_pkg::div_word_t  word_out
);
	import rlb_pkg::*;

	logic      v_s1;
	div_word_t word_s1;
	div_word_t w_c;
	logic [9:0] trial;

	// Remainder stays below the divisor on dividing lanes that do not saturate, so it fits nine bits after each step
	always_comb begin
		w_c   = word_in;
		trial = '0;
		for (int i = 0; i < NumLanes; i++) begin
			for (int b = 0; b < BitsPerDiv; b++) begin
				trial = {w_c.lanes[i].rem, w_c.lanes[i].lo[7]};
				w_c.lanes[i].lo = {w_c.lanes[i].lo[6:0], 1'b0};
				if (trial >= {1'b0, w_c.lanes[i].den}) begin
					trial = trial - {1'b0, w_c.lanes[i].den};
					w_c.lanes[i].quo = {w_c.lanes[i].quo[6:0], 1'b1};
				end else begin
					w_c.lanes[i].quo = {w_c.lanes[i].quo[6:0], 1'b0};
				end
				w_c.lanes[i].rem = trial[8:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= w_c;
	end

	assign out_valid = v_s1;
	assign word_out  = word_s1;

	a_rem_lane0: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && word_s1.lanes[0].use_div && !word_s1.lanes[0].sat
		|-> word_s1.lanes[0].rem < word_s1.lanes[0].den)
		else $error("lane 0 remainder not below divisor");
	a_rem_lane1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && word_s1.lanes[1].use_div && !word_s1.lanes[1].sat
		|-> word_s1.lanes[1].rem < word_s1.lanes[1].den)
		else $error("lane 1 remainder not below divisor");
	a_rem_lane2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && word_s1.lanes[2].use_div && !word_s1.lanes[2].sat
		|-> word_s1.lanes[2].rem < word_s1.lanes[2].den)
		else $error("lane 2 remainder not below divisor");

endmodule

[design/rgba_layer_blend_unit_core.sv]
// ----------------------------------------------------------------------------
// rgba_layer_blend_unit_core
// Blends a source RGBA8 pixel onto a destination pixel under a layer mode.
// ----------------------------------------------------------------------------
// One pixel pair is taken every cycle (busy is always low) and its result
// appears on result with done high after passing five arithmetic
// stages, four divider stages of two quotient bits each, and an output
// register. The receiver cannot stall, so results must be taken as they come.
// Write blend_mode only while no transaction is in flight.
module rgba_layer_blend_unit_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rlb_pkg::pixel_in_t  pixel,
	input  logic                mode_we,
	input  logic [3:0]          mode_wdata,
	output logic                done,
	output rlb_pkg::pixel_out_t result
);
	import rlb_pkg::*;

	logic [3:0]  mode_q;
	logic        v_st [DivStages+1];
	div_word_t   w_st [DivStages+1];
	logic        done_q;
	pixel_out_t  result_q;
	logic [7:0]  ch [NumLanes];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	assign busy = 1'b0;

	rlb_arith u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.pixel     (pixel),
		.mode      (mode_q),
		.out_valid (v_st[0]),
		.word      (w_st[0])
	);

	for (genvar g = 0; g < DivStages; g++) begin : g_div
		rlb_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_st[g]),
			.word_in   (w_st[g]),
			.out_valid (v_st[g+1]),
			.word_out  (w_st[g+1])
		);
	end

	// Pick quotient, saturated value or the ready-made channel
	always_comb begin
		for (int i = 0; i < NumLanes; i++) begin
			if (w_st[DivStages].lanes[i].sat) begin
				ch[i] = 8'd255;
			end else if (w_st[DivStages].lanes[i].use_div) begin
				ch[i] = w_st[DivStages].lanes[i].quo;
			end else begin
				ch[i] = w_st[DivStages].lanes[i].alt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_st[DivStages];
		end
	end

	always_ff @(posedge clk) begin
		result_q.out_red   <= ch[0];
		result_q.out_green <= ch[1];
		result_q.out_blue  <= ch[2];
		result_q.out_alpha <= w_st[DivStages].alpha;
	end

	assign done   = done_q;
	assign result = result_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 10))
		else $error("result without a transaction ten cycles earlier");

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGBA layer blend core: drives pixel pairs
// under every blend mode, predicts each blended pixel and checks the results.
// ----------------------------------------------------------------------------
import rlb_pkg::*;

class blend_scoreboard;
	pixel_out_t pending[$];
	logic [3:0] mode;
	int         errors;
	int         checked;

	function logic [7:0] screen_ch(int s, int d);
		return 8'(255 - (((255 - d) * (255 - s)) >> 8));
	endfunction

	function logic [7:0] blend_ch(int s, int d);
		int v;
		case (mode)
			MODE_ADD:     v = (d + s > 255) ? 255 : d + s;
			MODE_SUB:     v = (d > s) ? d - s : 0;
			MODE_DIFF:    v = (d > s) ? d - s : s - d;
			MODE_DARKEN:  v = (d < s) ? d : s;
			MODE_LIGHTEN: v = (d > s) ? d : s;
			MODE_MULT:    v = (d * s) >> 8;
			MODE_DIV: begin
				v = (d * 256) / (s + 1);
				if (v > 255) v = 255;
			end
			MODE_SCREEN:  v = screen_ch(s, d);
			default:      v = (d * screen_ch(s, d) + (255 - d) * ((d * s) >> 8)) >> 8;
		endcase
		return 8'(v);
	endfunction

	function pixel_out_t blend(pixel_in_t p);
		pixel_out_t r;
		int s[3], d[3], sa, da, na, t, dw, v;
		s = '{p.src_red, p.src_green, p.src_blue};
		d = '{p.dst_red, p.dst_green, p.dst_blue};
		sa = p.src_opacity;
		da = p.dst_alpha;
		r = '{p.dst_red, p.dst_green, p.dst_blue, p.dst_alpha};
		if (mode == MODE_NORMAL) begin
			if (sa != 0) begin
				t = (255 - da) * sa + 'h80;
				na = da + (((t >> 8) + t) >> 8);
				if (na > 255) na = 255;
				if (na != 0) begin
					dw = (na >= sa) ? na - sa : 0;
					for (int i = 0; i < 3; i++) begin
						v = (s[i] * sa + d[i] * dw) / na;
						if (v > 255) v = 255;
						d[i] = v;
					end
					r = '{8'(d[0]), 8'(d[1]), 8'(d[2]), 8'(na)};
				end
			end
		end else if (mode <= MODE_OVERLAY) begin
			r = '{blend_ch(s[0], d[0]), blend_ch(s[1], d[1]), blend_ch(s[2], d[2]),
				p.src_opacity};
		end
		return r;
	endfunction

	function void note_pixel(pixel_in_t p);
		pending.push_back(blend(p));
	endfunction

	function void check_result(pixel_out_t got);
		pixel_out_t exp;
		if (pending.size() == 0) begin
			$error("result with no pixel pending: %h", got);
			errors++;
			return;
		end
		exp = pending.pop_front();
		checked++;
		if (got.out_red !== exp.out_red) begin
			$error("out_red expected %0d got %0d", exp.out_red, got.out_red);
			errors++;
		end
		if (got.out_green !== exp.out_green) begin
			$error("out_green expected %0d got %0d", exp.out_green, got.out_green);
			errors++;
		end
		if (got.out_blue !== exp.out_blue) begin
			$error("out_blue expected %0d got %0d", exp.out_blue, got.out_blue);
			errors++;
		end
		if (got.out_alpha !== exp.out_alpha) begin
			$error("out_alpha expected %0d got %0d", exp.out_alpha, got.out_alpha);
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	pixel_in_t  pixel = '0;
	logic       mode_we = 1'b0;
	logic [3:0] mode_wdata = '0;
	logic       done;
	pixel_out_t result;

	blend_scoreboard sb = new();
	int   idle_pct = 0;
	int   cycles = 0;
	int   sent = 0;
	int   modes_seen = 0;

	always #2 clk = ~clk;

	rgba_layer_blend_unit_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel(pixel),
		.mode_we(mode_we), .mode_wdata(mode_wdata), .done(done), .result(result)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (done) sb.check_result(result);
		if (cycles > 200000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Leave start high after the transaction; an idle gap in the next send or a drain drops it
	task automatic send_pixel(input pixel_in_t p);
		while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_pixel(p);
		sent++;
	endtask

	// Hold until every transaction has come back, plus a wait longer than the pipeline depth
	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (14) @(posedge clk);
	endtask

	task automatic set_mode(input logic [3:0] m);
		drain();
		mode_we <= 1'b1;
		mode_wdata <= m;
		@(posedge clk);
		mode_we <= 1'b0;
		sb.mode = m;
		modes_seen++;
	endtask

	function automatic pixel_in_t rand_pixel();
		pixel_in_t p;
		p = pixel_in_t'({$urandom, $urandom});
		case ($urandom_range(7, 0))
			0: p.src_opacity = 8'd0;
			1: p.src_opacity = 8'd255;
			2: p.dst_alpha = 8'd0;
			3: p.dst_alpha = 8'd255;
			default: ;
		endcase
		return p;
	endfunction

	initial begin
		pixel_in_t p;
		logic [3:0] m;
		sb.mode = MODE_NORMAL;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes in reset mode, then corners under every mode
		send_pixel('1);
		send_pixel('0);
		send_pixel({8'd200, 8'd10, 8'd90, 8'd0, 8'd1, 8'd2, 8'd3, 8'd77});
		send_pixel({8'd200, 8'd10, 8'd90, 8'd255, 8'd1, 8'd2, 8'd3, 8'd77});
		send_pixel({8'd255, 8'd0, 8'd128, 8'd1, 8'd0, 8'd255, 8'd128, 8'd0});
		for (int k = 0; k < 16; k++) begin
			set_mode(4'(k));
			send_pixel({8'd255, 8'd0, 8'd128, 8'd90, 8'd0, 8'd255, 8'd200, 8'd40});
		end

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 32 : (phase == 1) ? 65 : 0;
			for (int blk = 0; blk < 6; blk++) begin
				m = (blk == 0) ? 4'd0 : (blk == 1) ? 4'd15 : 4'($urandom_range(15, 0));
				if ($urandom_range(3, 0) != 0 && blk > 1) m = 4'($urandom_range(9, 0));
				set_mode(m);
				for (int i = 0; i < 47; i++) begin
					p = rand_pixel();
					send_pixel(p);
				end
			end
		end
		set_mode(MODE_OVERLAY);
		for (int i = 0; i < 10; i++) send_pixel(rand_pixel());
		drain();

		$display("Sent %0d pixel pairs across %0d mode writes; %0d results checked.",
			sent, modes_seen, sb.checked);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

[rgba_layer_blend_unit_core.f]
design/rlb_pkg.sv
design/rlb_arith.sv
design/rlb_div_stage.sv
design/rgba_layer_blend_unit_core.sv
tb/sv/tb_top.sv
